>>> design/chq_pkg.sv
// ----------------------------------------------------------------------------
// chq_pkg
// Shared types and constants of the cumulative histogram quantile core.
// ----------------------------------------------------------------------------
package chq_pkg;

  localparam int QUO_W = 17;
  localparam int QCNT_W = 5;
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUANT = 2'd2,
    OP_PROP  = 2'd3
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  bin;
    logic [15:0] weight;
    logic [16:0] prop_q16;
    logic [16:0] position_q8;
  } req_t;

  typedef struct packed {
    logic [24:0] value_q16;
    logic [16:0] proportion_q16;
    logic        status;
  } res_t;

endpackage

>>> design/cumulative_histogram_quantile_core.sv
// ----------------------------------------------------------------------------
// cumulative_histogram_quantile_core
// Histogram with saturating bins, prefix-sum build, quantile and
// cumulative-proportion queries.
//
// A command transfer happens when start is high and busy is low; req_i
// carries the operation and its operands. Each command yields one result on
// res_o, shown for exactly one cycle with done_o high. The receiver cannot
// stall; results must be taken in the cycle they appear.
// An add reads and then writes its bin. A build reads one bin per cycle and
// writes the prefix sums. A quantile query runs a shift-add multiply, a
// binary search over the prefix sums and the serial divider; a proportion
// query reads two prefix sums, weights them and divides by the total. A
// query on a stale table answers with status high and no search. Items are
// processed one at a time; busy is high until the result is shown. The bin
// and prefix-sum memories have one read port each, which sets the pace of
// the build and search. After reset the block sweeps the bin memory to
// zero, holding busy high while it does so.
// ----------------------------------------------------------------------------
module cumulative_histogram_quantile_core #(
  parameter int NUM_BINS    = 256,
  parameter int COUNT_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  chq_pkg::req_t req_i,
  output logic          done_o,
  output chq_pkg::res_t res_o
);

  localparam int AW = $clog2(NUM_BINS);
  localparam int CW = COUNT_WIDTH + AW;
  localparam int TW = CW + chq_pkg::QUO_W;
  localparam int PW = CW + 9;
  localparam int SW = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;
  localparam int unsigned FULL_POS = NUM_BINS * 256;
  localparam longint FULL_VAL = longint'(NUM_BINS) * 65536;
  localparam logic [COUNT_WIDTH-1:0] MAXC = '1;
  localparam logic [AW-1:0] LAST = AW'(NUM_BINS - 1);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_ADD_RD, S_ADD_WR, S_BUILD, S_Q_MUL, S_Q_RD0, S_Q_RDL,
    S_Q_CHK, S_SRCH, S_SRCH_CMP, S_Q_J, S_Q_RDA, S_Q_RDB, S_Q_AB, S_P_RDA,
    S_P_RDB, S_P_SUM, S_DIV
  } state_e;

  state_e state_q;

  logic [COUNT_WIDTH-1:0] bin_mem [NUM_BINS];
  logic [CW-1:0]          cum_mem [NUM_BINS];
  logic [COUNT_WIDTH-1:0] bin_rd_q;
  logic [CW-1:0]          cum_rd_q;

  logic [AW:0]      cnt_q;
  logic             op_prop_q;
  logic [AW-1:0]    bin_q;
  logic [15:0]      weight_q;
  logic [CW-1:0]    sum_q;
  logic [CW-1:0]    total_q;
  logic             valid_q;
  logic [TW-1:0]    t16_q;
  logic [TW-1:0]    mcand_q;
  logic [16:0]      mplier_q;
  logic [CW-1:0]    c0_q;
  logic [CW-1:0]    ca_q;
  logic [AW-1:0]    lo_q;
  logic [AW-1:0]    hi_q;
  logic [AW-1:0]    mid_q;
  logic [AW-1:0]    k_q;
  logic [AW-1:0]    i_q;
  logic [AW-1:0]    ib_q;
  logic [8:0]       f_q;
  logic             p_low_q;
  logic [PW-1:0]    acc_q;
  logic             mid_div_q;
  logic             div_go_q;
  logic [TW-1:0]    div_n_q;
  logic [CW-1:0]    div_d_q;
  logic             done_q;
  chq_pkg::res_t    res_q;

  logic                   div_done;
  logic [chq_pkg::QUO_W-1:0] div_q;

  logic                   bin_we;
  logic [AW-1:0]          bin_waddr;
  logic [AW-1:0]          bin_raddr;
  logic [COUNT_WIDTH-1:0] bin_wdata;
  logic [SW-1:0]          sat_sum;
  logic                   cum_we;
  logic [AW-1:0]          cum_waddr;
  logic [AW-1:0]          cum_raddr;
  logic [CW-1:0]          sum_new;
  logic [TW-1:0]          rd_sh;
  logic [AW:0]            lohi;
  logic [AW-1:0]          mid;
  logic [16:0]            prop_clip;
  logic [16:0]            pos_y;
  logic [8:0]             pos_i;
  logic [AW-1:0]          pos_ic;
  logic                   in_range;
  logic [32:0]            k_ext;
  logic [PW-1:0]          v_sum;

  always_comb begin
    sat_sum   = SW'(bin_rd_q) + SW'(weight_q);
    bin_we    = (state_q == S_CLEAR) || (state_q == S_ADD_WR);
    bin_waddr = (state_q == S_CLEAR) ? cnt_q[AW-1:0] : bin_q;
    if (state_q == S_CLEAR) begin
      bin_wdata = '0;
    end else if (sat_sum > SW'(MAXC)) begin
      bin_wdata = MAXC;
    end else begin
      bin_wdata = sat_sum[COUNT_WIDTH-1:0];
    end
    bin_raddr = (state_q == S_BUILD) ? cnt_q[AW-1:0] : bin_q;
    sum_new   = sum_q + CW'(bin_rd_q);
    cum_we    = (state_q == S_BUILD) && (cnt_q != '0);
    cum_waddr = AW'(cnt_q - 1'b1);
    rd_sh     = TW'({cum_rd_q, 16'h0});
    lohi      = {1'b0, lo_q} + {1'b0, hi_q};
    mid       = lohi[AW:1];
    case (state_q)
      S_Q_RDL: cum_raddr = LAST;
      S_SRCH:  cum_raddr = (lo_q < hi_q) ? mid : lo_q;
      S_Q_RDA: cum_raddr = k_q;
      S_Q_RDB: cum_raddr = AW'(k_q + 1'b1);
      S_P_RDA: cum_raddr = i_q;
      S_P_RDB: cum_raddr = ib_q;
      default: cum_raddr = '0;
    endcase
    prop_clip = (req_i.prop_q16 > chq_pkg::ONE_Q16) ? chq_pkg::ONE_Q16 : req_i.prop_q16;
    pos_y     = req_i.position_q8 - 17'd256;
    pos_i     = pos_y[16:8];
    pos_ic    = (32'(pos_i) >= 32'(NUM_BINS - 1)) ? AW'(NUM_BINS - 2) : AW'(32'(pos_i));
    in_range  = 32'(req_i.bin) < 32'(NUM_BINS);
    k_ext     = 33'(k_q);
    v_sum     = acc_q + PW'(PW'(cum_rd_q) * PW'(f_q));
  end

  always_ff @(posedge clk_i) begin
    if (bin_we) begin
      bin_mem[bin_waddr] <= bin_wdata;
    end
    bin_rd_q <= bin_mem[bin_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cum_we) begin
      cum_mem[cum_waddr] <= sum_new;
    end
    cum_rd_q <= cum_mem[cum_raddr];
  end

  chq_div #(
    .DW(CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go_q),
    .dividend_i (div_n_q),
    .divisor_i  (div_d_q),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      cnt_q     <= '0;
      op_prop_q <= 1'b0;
      bin_q     <= '0;
      weight_q  <= '0;
      sum_q     <= '0;
      total_q   <= '0;
      valid_q   <= 1'b0;
      t16_q     <= '0;
      mcand_q   <= '0;
      mplier_q  <= '0;
      c0_q      <= '0;
      ca_q      <= '0;
      lo_q      <= '0;
      hi_q      <= '0;
      mid_q     <= '0;
      k_q       <= '0;
      i_q       <= '0;
      ib_q      <= '0;
      f_q       <= '0;
      p_low_q   <= 1'b0;
      acc_q     <= '0;
      mid_div_q <= 1'b0;
      div_go_q  <= 1'b0;
      div_n_q   <= '0;
      div_d_q   <= '0;
      done_q    <= 1'b0;
      res_q     <= '0;
    end else begin
      done_q   <= 1'b0;
      div_go_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q[AW-1:0] == LAST) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            res_q     <= '0;
            op_prop_q <= (req_i.op == chq_pkg::OP_PROP);
            bin_q     <= AW'(32'(req_i.bin));
            weight_q  <= req_i.weight;
            unique case (req_i.op)
              chq_pkg::OP_ADD: begin
                if (in_range) begin
                  state_q <= S_ADD_RD;
                end else begin
                  done_q <= 1'b1;
                end
              end
              chq_pkg::OP_BUILD: begin
                cnt_q   <= '0;
                sum_q   <= '0;
                state_q <= S_BUILD;
              end
              chq_pkg::OP_QUANT: begin
                if (!valid_q) begin
                  res_q.status <= 1'b1;
                  done_q       <= 1'b1;
                end else begin
                  t16_q    <= '0;
                  mcand_q  <= TW'(total_q);
                  mplier_q <= prop_clip;
                  state_q  <= S_Q_MUL;
                end
              end
              default: begin
                if (!valid_q) begin
                  res_q.status <= 1'b1;
                  done_q       <= 1'b1;
                end else if (req_i.position_q8 == '0) begin
                  done_q <= 1'b1;
                end else if (req_i.position_q8 <= 17'd256) begin
                  if (total_q == '0) begin
                    done_q <= 1'b1;
                  end else begin
                    i_q     <= '0;
                    ib_q    <= '0;
                    f_q     <= 9'(req_i.position_q8);
                    p_low_q <= 1'b1;
                    state_q <= S_P_RDA;
                  end
                end else if (32'(req_i.position_q8) >= FULL_POS) begin
                  res_q.proportion_q16 <= chq_pkg::ONE_Q16;
                  done_q               <= 1'b1;
                end else if (total_q == '0) begin
                  done_q <= 1'b1;
                end else begin
                  i_q     <= pos_ic;
                  ib_q    <= AW'(pos_ic + 1'b1);
                  f_q     <= {1'b0, pos_y[7:0]};
                  p_low_q <= 1'b0;
                  state_q <= S_P_RDA;
                end
              end
            endcase
          end
        end
        S_ADD_RD: begin
          state_q <= S_ADD_WR;
        end
        S_ADD_WR: begin
          valid_q <= 1'b0;
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        S_BUILD: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q != '0) begin
            sum_q <= sum_new;
          end
          if (cnt_q == (AW + 1)'(NUM_BINS)) begin
            total_q <= sum_new;
            valid_q <= 1'b1;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_Q_MUL: begin
          if (mplier_q == '0) begin
            state_q <= S_Q_RD0;
          end else begin
            if (mplier_q[0]) begin
              t16_q <= t16_q + mcand_q;
            end
            mcand_q  <= {mcand_q[TW-2:0], 1'b0};
            mplier_q <= {1'b0, mplier_q[16:1]};
          end
        end
        S_Q_RD0: begin
          state_q <= S_Q_RDL;
        end
        S_Q_RDL: begin
          c0_q    <= cum_rd_q;
          state_q <= S_Q_CHK;
        end
        S_Q_CHK: begin
          if (t16_q < TW'({c0_q, 16'h0})) begin
            if ((total_q == '0) || (c0_q == '0)) begin
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              div_n_q   <= t16_q;
              div_d_q   <= c0_q;
              mid_div_q <= 1'b0;
              div_go_q  <= 1'b1;
              state_q   <= S_DIV;
            end
          end else if (t16_q >= rd_sh) begin
            res_q.value_q16 <= 25'(FULL_VAL);
            done_q          <= 1'b1;
            state_q         <= S_IDLE;
          end else begin
            lo_q    <= '0;
            hi_q    <= LAST;
            state_q <= S_SRCH;
          end
        end
        S_SRCH: begin
          mid_q   <= mid;
          state_q <= (lo_q < hi_q) ? S_SRCH_CMP : S_Q_J;
        end
        S_SRCH_CMP: begin
          if (rd_sh >= t16_q) begin
            hi_q <= mid_q;
          end else begin
            lo_q <= AW'(mid_q + 1'b1);
          end
          state_q <= S_SRCH;
        end
        S_Q_J: begin
          k_q     <= (rd_sh == t16_q) ? lo_q : AW'(lo_q - 1'b1);
          state_q <= S_Q_RDA;
        end
        S_Q_RDA: begin
          state_q <= S_Q_RDB;
        end
        S_Q_RDB: begin
          ca_q    <= cum_rd_q;
          state_q <= S_Q_AB;
        end
        S_Q_AB: begin
          if (ca_q >= cum_rd_q) begin
            res_q.value_q16 <= 25'(k_ext << 16);
            done_q          <= 1'b1;
            state_q         <= S_IDLE;
          end else begin
            div_n_q   <= t16_q - TW'({ca_q, 16'h0});
            div_d_q   <= cum_rd_q - ca_q;
            mid_div_q <= 1'b1;
            div_go_q  <= 1'b1;
            state_q   <= S_DIV;
          end
        end
        S_P_RDA: begin
          state_q <= S_P_RDB;
        end
        S_P_RDB: begin
          acc_q   <= p_low_q ? '0 : PW'(PW'(cum_rd_q) * PW'(9'd256 - f_q));
          state_q <= S_P_SUM;
        end
        S_P_SUM: begin
          div_n_q   <= TW'({v_sum[PW-2:0], 8'h0});
          div_d_q   <= total_q;
          mid_div_q <= 1'b0;
          div_go_q  <= 1'b1;
          state_q   <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (op_prop_q) begin
              res_q.proportion_q16 <= div_q;
            end else if (mid_div_q) begin
              res_q.value_q16 <= 25'(((k_ext + 33'd1) << 16) + 33'(div_q));
            end else begin
              res_q.value_q16 <= 25'(div_q);
            end
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> design/chq_div.sv
// ----------------------------------------------------------------------------
// chq_div
// Serial restoring divider producing one quotient bit per cycle. The
// dividend must be below the divisor shifted left by the quotient width.
// ----------------------------------------------------------------------------
module chq_div #(
  parameter int DW = 40
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [DW+chq_pkg::QUO_W-1:0]  dividend_i,
  input  logic [DW-1:0]                 divisor_i,
  output logic                          done_o,
  output logic [chq_pkg::QUO_W-1:0]     quotient_o
);

  localparam int QW = chq_pkg::QUO_W;

  logic                          run_q;
  logic                          done_q;
  logic [chq_pkg::QCNT_W-1:0]    cnt_q;
  logic [DW-1:0]                 rem_q;
  logic [DW-1:0]                 den_q;
  logic [QW-1:0]                 num_q;
  logic [QW-1:0]                 quo_q;
  logic [DW:0]                   trial;
  logic                          ge;

  always_comb begin
    trial = {rem_q, num_q[QW-1]};
    ge    = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      num_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= chq_pkg::QCNT_W'(QW);
        rem_q <= dividend_i[DW+QW-1:QW];
        num_q <= dividend_i[QW-1:0];
        den_q <= divisor_i;
        quo_q <= '0;
      end else if (run_q) begin
        rem_q <= ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
        num_q <= {num_q[QW-2:0], 1'b0};
        quo_q <= {quo_q[QW-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == chq_pkg::QCNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
